FILE: rtl/bdq_pkg.sv
// ============================================================================
// bdq_pkg
// Shared types, codes and defaults for the bounded deque with remove.
// ============================================================================
`default_nettype none

package bdq_pkg;

    // Default capacity and derived widths
    localparam int DEPTH_DEF = 16;
    localparam int CNT_W_DEF = $clog2(DEPTH_DEF + 1);

    // Fixed payload widths
    localparam int DATA_W = 32;
    localparam int ACT_W  = 3;
    localparam int ST_W   = 2;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUSH         = 3'd0;
    localparam logic [ACT_W-1:0] ACT_POP          = 3'd1;
    localparam logic [ACT_W-1:0] ACT_APPEND       = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE_FIRST = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVE_ALL   = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR        = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_POP,
        S_SCAN,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/bdq_req_if.sv
// ============================================================================
// bdq_req_if
// Request channel: valid/ready handshake carrying action and value.
// ============================================================================
`default_nettype none

interface bdq_req_if
    import bdq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/bdq_rsp_if.sv
// ============================================================================
// bdq_rsp_if
// Response channel: valid/ready handshake carrying one result per request.
// ============================================================================
`default_nettype none

interface bdq_rsp_if
    import bdq_pkg::*;
#(
    parameter int CNT_W = CNT_W_DEF
);
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data;
    logic [ST_W-1:0]          status;
    logic [CNT_W-1:0]         count;
    logic [CNT_W-1:0]         removed;

    modport source (output valid, output data, output status, output count,
                    output removed, input ready);
    modport sink   (input valid, input data, input status, input count,
                    input removed, output ready);
endinterface

`default_nettype wire

FILE: rtl/bdq_store.sv
// ============================================================================
// bdq_store
// Entry memory: one write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module bdq_store
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
)(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/bounded_deque_with_remove.sv
// ============================================================================
// bounded_deque_with_remove
// Ordered store of up to DEPTH signed words, used as a double-ended list.
// ============================================================================
// One request is handled at a time; req.ready is high only while the sequencer
// is idle, and one response follows each request. An accepted request moves
// to S_EXEC; push, append, clear and unused codes then go to S_RESP, pop goes
// through S_POP, and either removal goes through S_SCAN, where a single
// comparator walks the held entries through the one read port of the entry
// memory, one entry per cycle, writing survivors back toward the front to
// keep their order. A pop or removal on an empty store goes from S_EXEC
// straight to S_RESP. A new request may be accepted while the previous
// response still waits in the output register; the new response then waits
// in S_RESP until that register is free. Entries are held in a circular
// buffer that is not cleared at reset; only written positions are ever
// read.
`default_nettype none

module bounded_deque_with_remove
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bdq_req_if.sink    req,
    bdq_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    // Sequencer and list state
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // Captured request
    logic [ACT_W-1:0]   act_reg;
    logic [DATA_W-1:0]  val_reg;

    // Scan counters
    logic [CNT_W-1:0]   rd_off_reg, rd_off_next;
    logic [CNT_W-1:0]   kept_reg, kept_next;
    logic [CNT_W-1:0]   gone_reg, gone_next;
    logic               pv_reg, pv_next;

    // Pending result
    logic [DATA_W-1:0]  res_data_reg, res_data_next;
    logic [ST_W-1:0]    res_status_reg, res_status_next;
    logic [CNT_W-1:0]   res_removed_reg, res_removed_next;

    // Output register
    logic               rsp_valid_reg, rsp_valid_next;
    logic [DATA_W-1:0]  rsp_data_reg;
    logic [ST_W-1:0]    rsp_status_reg;
    logic [CNT_W-1:0]   rsp_count_reg;
    logic [CNT_W-1:0]   rsp_removed_reg;

    // Memory port controls
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [DATA_W-1:0]  rd_data;

    logic               req_xfer;
    logic               rsp_load;
    logic               scan_done;
    logic               hit;

    // Position of the entry at a given offset from the front
    function automatic logic [IDX_W-1:0] slot_of(
        input logic [IDX_W-1:0] front,
        input logic [CNT_W-1:0] off
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    bdq_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_xfer  = req.valid && req.ready;
    assign rsp_load  = (state_reg == S_RESP) && (!rsp_valid_reg || rsp.ready);
    assign scan_done = (rd_off_reg == count_reg) && !pv_reg;
    assign hit       = (rd_data == val_reg)
                       && ((act_reg == ACT_REMOVE_ALL) || (gone_reg == '0));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (act_reg)
                    ACT_POP:
                    begin
                        state_next = (count_reg == '0) ? S_RESP : S_POP;
                    end
                    ACT_REMOVE_FIRST, ACT_REMOVE_ALL:
                    begin
                        state_next = (count_reg == '0) ? S_RESP : S_SCAN;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_POP:
            begin
                state_next = S_RESP;
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        front_next       = front_reg;
        count_next       = count_reg;
        rd_off_next      = rd_off_reg;
        kept_next        = kept_reg;
        gone_next        = gone_reg;
        pv_next          = pv_reg;
        res_data_next    = res_data_reg;
        res_status_next  = res_status_reg;
        res_removed_next = res_removed_reg;
        wr_en            = 1'b0;
        wr_addr          = '0;
        wr_data          = val_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;

        case (state_reg)
            S_EXEC:
            begin
                res_data_next    = '0;
                res_status_next  = ST_OK;
                res_removed_next = '0;
                case (act_reg)
                    ACT_PUSH:
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            front_next = (front_reg == '0) ? IDX_LAST
                                                           : front_reg - 1'b1;
                            wr_en      = 1'b1;
                            wr_addr    = front_next;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    ACT_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = front_reg;
                        end
                    end
                    ACT_APPEND:
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = slot_of(front_reg, count_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    ACT_REMOVE_FIRST, ACT_REMOVE_ALL:
                    begin
                        rd_off_next = '0;
                        kept_next   = '0;
                        gone_next   = '0;
                        pv_next     = 1'b0;
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        res_removed_next = count_reg;
                        count_next       = '0;
                        front_next       = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_POP:
            begin
                res_data_next = rd_data;
                front_next    = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;
                count_next    = count_reg - 1'b1;
            end
            S_SCAN:
            begin
                // Issue the next read while the previous word is compared
                if (rd_off_reg != count_reg)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = slot_of(front_reg, rd_off_reg);
                    rd_off_next = rd_off_reg + 1'b1;
                    pv_next     = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end
                // Drop a match or write the survivor back toward the front
                if (pv_reg)
                begin
                    if (hit)
                    begin
                        gone_next = gone_reg + 1'b1;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = slot_of(front_reg, kept_reg);
                        wr_data   = rd_data;
                        kept_next = kept_reg + 1'b1;
                    end
                end
                if (scan_done)
                begin
                    count_next       = kept_reg;
                    res_removed_next = gone_reg;
                    res_status_next  = (gone_reg == '0) ? ST_NOT_FOUND : ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output valid tracking
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rd_off_reg    <= '0;
            kept_reg      <= '0;
            gone_reg      <= '0;
            pv_reg        <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rd_off_reg    <= rd_off_next;
            kept_reg      <= kept_next;
            gone_reg      <= gone_next;
            pv_reg        <= pv_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            act_reg <= req.action;
            val_reg <= req.value;
        end
        res_data_reg    <= res_data_next;
        res_status_reg  <= res_status_next;
        res_removed_reg <= res_removed_next;
        if (rsp_load)
        begin
            rsp_data_reg    <= res_data_reg;
            rsp_status_reg  <= res_status_reg;
            rsp_count_reg   <= count_reg;
            rsp_removed_reg <= res_removed_reg;
        end
    end

    // Port outputs
    always_comb
    begin
        req.ready   = (state_reg == S_IDLE);
        rsp.valid   = rsp_valid_reg;
        rsp.data    = rsp_data_reg;
        rsp.status  = rsp_status_reg;
        rsp.count   = rsp_count_reg;
        rsp.removed = rsp_removed_reg;
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("entry count above capacity");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= IDX_LAST)
        else $error("front index out of range");

    a_scan_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |->
            ((SUM_W'(kept_reg) + SUM_W'(gone_reg) + SUM_W'(pv_reg))
             == SUM_W'(rd_off_reg)))
        else $error("scan counters out of step");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> (state_reg == S_EXEC))
        else $error("accepted request not dispatched");

    a_scan_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && scan_done |=> (count_reg <= $past(count_reg)))
        else $error("removal grew the list");

endmodule

`default_nettype wire
